[hw/rtl/lec_pkg.sv]
// Shared types and constants for the LIFO eviction cache.
// No dependencies; imported by every module of the block.
`default_nettype none

package lec_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int CMD_BITS    = 2;
  localparam int CAP_BITS    = 5;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_HAS = 2'd0,
    CMD_GET = 2'd1,
    CMD_SET = 2'd2
  } cmd_t;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef key_t   [MAX_ENTRIES-1:0] key_array_t;

  // Result of the parallel key search
  typedef struct packed {
    logic found;
    idx_t where;
  } lookup_t;

  // Update request from the request stage to the entry store
  typedef struct packed {
    logic   write;
    logic   found;
    idx_t   where;
    key_t   key;
    value_t value;
  } update_t;

endpackage

`default_nettype wire

[hw/rtl/lec_match.sv]
// Parallel key compare across all valid entries with a lowest-index priority pick.
// Depends on lec_pkg.
`default_nettype none

module lec_match
  import lec_pkg::*;
(
  input  key_array_t keys,
  input  cnt_t       count,
  input  key_t       key,
  output lookup_t    result
);

  logic [MAX_ENTRIES-1:0] match;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = (cnt_t'(i) < count) && (keys[i] == key);
    end
  end

  // Scan downward so the lowest matching index wins
  always_comb begin
    result.found = |match;
    result.where = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        result.where = idx_t'(i);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lec_store.sv]
// Entry store: key and value registers in insertion order plus the entry count.
// Applies overwrite, LIFO eviction and append. Depends on lec_pkg.
`default_nettype none

module lec_store
  import lec_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [CAP_BITS-1:0] capacity,
  input  update_t             upd,
  input  idx_t                rd_where,
  output key_array_t          keys,
  output value_t              rd_value,
  output cnt_t                count
);

  value_t values [MAX_ENTRIES];
  cnt_t   cap_eff;
  logic   evict;
  cnt_t   slot;
  logic   append;
  cnt_t   count_next;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = cnt_t'(1);
    end else if (capacity > CAP_BITS'(MAX_ENTRIES)) begin
      cap_eff = cnt_t'(MAX_ENTRIES);
    end else begin
      cap_eff = cnt_t'(capacity);
    end
  end

  // Drop the most recent entry when full, then append at the freed slot
  assign evict  = (count >= cap_eff) && (count != '0);
  assign slot   = evict ? count - cnt_t'(1) : count;
  assign append = upd.write && !upd.found && (slot < cnt_t'(MAX_ENTRIES));

  always_comb begin
    count_next = count;
    if (append) begin
      count_next = slot + cnt_t'(1);
    end
  end

  assign rd_value = values[rd_where];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.write && upd.found) begin
      values[upd.where] <= upd.value;
    end else if (append) begin
      keys[slot[IDX_W-1:0]]   <= upd.key;
      values[slot[IDX_W-1:0]] <= upd.value;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(MAX_ENTRIES))
    else $error("entry count above store depth");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> count == '0)
    else $error("store not empty after reset");

  a_grow: assert property (@(posedge clk) disable iff (rst)
    upd.write && !upd.found && count < cap_eff |=> count == $past(count) + cnt_t'(1))
    else $error("insert into non-full store did not grow count");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !upd.write || upd.found |=> $stable(count))
    else $error("count changed without an insert");

endmodule

`default_nettype wire

[hw/rtl/lifo_eviction_cache_unit.sv]
// Top level of the LIFO eviction cache: request register, lookup, store, result register.
// Depends on lec_pkg, lec_match and lec_store.
//
//   channel   signals                              handshake
//   request   start, busy, cmd, key, value_in      taken when start && !busy
//   result    done, key_ok, hit, value_out         one-cycle strobe on done
//   config    cfg_valid, cfg_ready, cfg_data       written when valid && ready
//
// One request per cycle. A request taken at one edge is registered, looked up and
// applied to the store during the next cycle; done pulses in the cycle after that.
// Lookup and store update share one cycle, so a following request sees the new state.
// busy and cfg_ready follow rst: no request or write is taken during reset.
// Reset empties the store and sets the capacity to 16. The receiver cannot stall.
`default_nettype none

module lifo_eviction_cache_unit
  import lec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_BITS-1:0]   cmd,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value_in,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_BITS-1:0]   cfg_data,
  output logic                  done,
  output logic                  key_ok,
  output logic                  hit,
  output logic [VALUE_BITS-1:0] value_out
);

  logic                req_valid;
  logic [CMD_BITS-1:0] req_cmd;
  key_t                req_key;
  value_t              req_value;
  logic [CAP_BITS-1:0] capacity;

  key_array_t keys;
  cnt_t       count;
  value_t     rd_value;
  lookup_t    look;
  update_t    upd;
  logic       req_ok;
  logic       is_get;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_cmd   <= cmd;
      req_key   <= key;
      req_value <= value_in;
    end
  end

  lec_match u_match (
    .keys   (keys),
    .count  (count),
    .key    (req_key),
    .result (look)
  );

  // Refuse the empty key and the unused command code
  assign req_ok = req_valid && (req_key != '0) &&
                  (req_cmd == CMD_HAS || req_cmd == CMD_GET || req_cmd == CMD_SET);
  assign is_get = req_cmd == CMD_GET;

  always_comb begin
    upd.write = req_ok && (req_cmd == CMD_SET);
    upd.found = look.found;
    upd.where = look.where;
    upd.key   = req_key;
    upd.value = req_value;
  end

  lec_store u_store (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .upd      (upd),
    .rd_where (look.where),
    .keys     (keys),
    .rd_value (rd_value),
    .count    (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    key_ok    <= req_ok;
    hit       <= req_ok && look.found;
    value_out <= (req_ok && is_get && look.found) ? rd_value : '0;
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted request produced no result strobe");

  a_hit_needs_ok: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> key_ok)
    else $error("hit reported on a refused request");

  a_value_get_only: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> value_out == '0)
    else $error("value returned without a hit");

endmodule

`default_nettype wire
